[hw/rtl/swsr_pkg.sv]
// ----------------------------------------------------------------------------
// swsr_pkg
// Shared types, register indexes and reset constants for the single-wire
// sensor reader.
// ----------------------------------------------------------------------------
package swsr_pkg;

    // Default bit count of one decoded read
    localparam int BITS_PER_BYTE_DEF = 8;

    // Action codes of an input transaction
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_START_LOW   = 3'd0;
    localparam logic [2:0] CFG_RELEASE     = 3'd1;
    localparam logic [2:0] CFG_RESP_LIMIT  = 3'd2;
    localparam logic [2:0] CFG_BIT_SAMPLE  = 3'd3;
    localparam logic [2:0] CFG_ONE_EXTRA   = 3'd4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration reset values
    localparam logic [15:0] START_LOW_RST  = 16'd20000;
    localparam logic [7:0]  RELEASE_RST    = 8'd40;
    localparam logic [7:0]  RESP_LIMIT_RST = 8'd200;
    localparam logic [7:0]  BIT_SAMPLE_RST = 8'd30;
    localparam logic [7:0]  ONE_EXTRA_RST  = 8'd40;

    // Sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_START_LOW = 3'd1,
        PH_RELEASE   = 3'd2,
        PH_RESP_LOW  = 3'd3,
        PH_RESP_HIGH = 3'd4,
        PH_WAIT_HIGH = 3'd5,
        PH_BIT_DELAY = 3'd6,
        PH_BIT_EXTRA = 3'd7
    } t_phase;

    // Timing configuration
    typedef struct packed {
        logic [15:0] start_low;
        logic [7:0]  release_wait;
        logic [7:0]  resp_limit;
        logic [7:0]  bit_sample;
        logic [7:0]  one_extra;
    } t_cfg;

    // Sequencer state apart from the bit index
    typedef struct packed {
        t_phase      phase;
        logic [15:0] tick_count;
        logic [7:0]  shift_value;
        logic        low_timed_out;
    } t_core;

    // One result transaction
    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       response_valid;
        logic       response_timeout;
        logic       byte_valid;
        logic [7:0] data_byte;
    } t_result;

endpackage

[hw/rtl/swsr_in_if.sv]
// ----------------------------------------------------------------------------
// swsr_in_if
// Tick channel: one transaction per sampled tick, carrying action and pin.
// ----------------------------------------------------------------------------
interface swsr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic       pin_level;

    modport source (output valid, output action, output pin_level, input ready);
    modport sink   (input valid, input action, input pin_level, output ready);
endinterface

[hw/rtl/swsr_out_if.sv]
// ----------------------------------------------------------------------------
// swsr_out_if
// Result channel: one transaction per accepted tick.
// ----------------------------------------------------------------------------
interface swsr_out_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       response_valid;
    logic       response_timeout;
    logic       byte_valid;
    logic [7:0] data_byte;

    modport source (output valid, output drive_low, output busy_res,
                    output response_valid, output response_timeout,
                    output byte_valid, output data_byte, input ready);
    modport sink   (input valid, input drive_low, input busy_res,
                    input response_valid, input response_timeout,
                    input byte_valid, input data_byte, output ready);
endinterface

[hw/rtl/swsr_step.sv]
// ----------------------------------------------------------------------------
// swsr_step
// Next-state and result logic of the sequencer for one tick.
// ----------------------------------------------------------------------------
module swsr_step
    import swsr_pkg::*;
#(
    parameter int BITS_PER_BYTE = BITS_PER_BYTE_DEF,
    parameter int BI_W          = $clog2(BITS_PER_BYTE + 1)
) (
    input  t_cfg            i_cfg,
    input  t_core           i_core,
    input  logic [BI_W-1:0] i_bit_idx,
    input  logic [1:0]      i_action,
    input  logic            i_pin,
    output t_core           o_core,
    output logic [BI_W-1:0] o_bit_idx,
    output t_result         o_res
);

    t_core           eff;
    logic [BI_W-1:0] eff_bi;
    logic [15:0]     tick_inc;
    logic [BI_W-1:0] bi_inc;
    logic            hit_start, hit_release, hit_limit, hit_sample, hit_extra;
    logic [7:0]      shift_in;
    logic            bit_done;
    logic            byte_end;

    // Command decode while idle: the command tick is the sequence's first tick
    always_comb begin
        eff    = i_core;
        eff_bi = i_bit_idx;
        if (i_core.phase == PH_IDLE) begin
            if (i_action == ACT_START) begin
                eff.phase      = PH_START_LOW;
                eff.tick_count = '0;
            end else if (i_action == ACT_READ) begin
                eff.phase       = PH_WAIT_HIGH;
                eff.tick_count  = '0;
                eff.shift_value = '0;
                eff_bi          = '0;
            end
        end
    end

    // Counter compares (a zero limit acts as one since tick_inc is at least one)
    assign tick_inc    = eff.tick_count + 16'd1;
    assign hit_start   = tick_inc >= i_cfg.start_low;
    assign hit_release = tick_inc >= 16'(i_cfg.release_wait);
    assign hit_limit   = tick_inc >= 16'(i_cfg.resp_limit);
    assign hit_sample  = tick_inc >= 16'(i_cfg.bit_sample);
    assign hit_extra   = tick_inc >= 16'(i_cfg.one_extra);
    assign shift_in    = {eff.shift_value[6:0], i_pin};
    assign bi_inc      = eff_bi + BI_W'(1);
    assign byte_end    = bi_inc >= BI_W'(BITS_PER_BYTE);

    assign bit_done = ((eff.phase == PH_BIT_DELAY) && hit_sample &&
                       !(i_pin && (i_cfg.one_extra != 8'd0))) ||
                      ((eff.phase == PH_BIT_EXTRA) && hit_extra);

    // Next state
    always_comb begin
        o_core    = eff;
        o_bit_idx = eff_bi;
        unique case (eff.phase)
            PH_IDLE: begin
            end
            PH_START_LOW: begin
                o_core.tick_count = tick_inc;
                if (hit_start) begin
                    o_core.tick_count = '0;
                    o_core.phase = (i_cfg.release_wait == 8'd0) ? PH_RESP_LOW : PH_RELEASE;
                end
            end
            PH_RELEASE: begin
                o_core.tick_count = tick_inc;
                if (hit_release) begin
                    o_core.tick_count = '0;
                    o_core.phase      = PH_RESP_LOW;
                end
            end
            PH_RESP_LOW: begin
                if (!i_pin) begin
                    o_core.tick_count = tick_inc;
                    if (hit_limit) begin
                        o_core.low_timed_out = 1'b1;
                        o_core.tick_count    = '0;
                        o_core.phase         = PH_RESP_HIGH;
                    end
                end else begin
                    o_core.low_timed_out = 1'b0;
                    o_core.tick_count    = '0;
                    o_core.phase         = PH_RESP_HIGH;
                end
            end
            PH_RESP_HIGH: begin
                if (i_pin)
                    o_core.tick_count = tick_inc;
                if (!i_pin || hit_limit) begin
                    o_core.tick_count = '0;
                    o_core.phase      = PH_IDLE;
                end
            end
            PH_WAIT_HIGH: begin
                if (i_pin) begin
                    o_core.tick_count = '0;
                    o_core.phase      = PH_BIT_DELAY;
                end
            end
            PH_BIT_DELAY: begin
                o_core.tick_count = tick_inc;
                if (hit_sample) begin
                    o_core.shift_value = shift_in;
                    o_core.tick_count  = '0;
                    if (i_pin && (i_cfg.one_extra != 8'd0))
                        o_core.phase = PH_BIT_EXTRA;
                end
            end
            PH_BIT_EXTRA: begin
                o_core.tick_count = tick_inc;
                if (hit_extra)
                    o_core.tick_count = '0;
            end
            default: o_core.phase = PH_IDLE;
        endcase

        // Bit completion: next bit or end of byte
        if (bit_done) begin
            if (byte_end) begin
                o_bit_idx    = '0;
                o_core.phase = PH_IDLE;
            end else begin
                o_bit_idx    = bi_inc;
                o_core.phase = PH_WAIT_HIGH;
            end
        end
    end

    // Result fields
    always_comb begin
        o_res                = '0;
        o_res.busy_res       = (eff.phase != PH_IDLE);
        o_res.drive_low      = (eff.phase == PH_START_LOW);
        if ((eff.phase == PH_RESP_HIGH) && (!i_pin || hit_limit)) begin
            o_res.response_valid   = 1'b1;
            o_res.response_timeout = eff.low_timed_out;
        end
        if (bit_done && byte_end) begin
            o_res.byte_valid = 1'b1;
            o_res.data_byte  = (eff.phase == PH_BIT_DELAY) ? shift_in : eff.shift_value;
        end
    end

endmodule

[hw/rtl/single_wire_sensor_reader.sv]
// ----------------------------------------------------------------------------
// single_wire_sensor_reader
// Host side of a single-wire sensor link: start pulse, response check and
// MSB-first byte read, stepped by one tick transaction at a time.
// ----------------------------------------------------------------------------
// Usage:
//  i_in carries one transaction per microsecond tick: the action code
//  (tick, start, read) and the sampled data-line level. Every accepted
//  transaction produces exactly one result transaction on o_out with the
//  line drive, busy flag, response flag and decoded byte.
//  The state update and the result are computed combinationally in the
//  accept cycle; the result sits in the output register in the next cycle.
//  Throughput is one transaction per cycle while results are taken; the
//  output register lets a new tick enter in the same cycle the pending
//  result is taken. When the receiver stalls, the held result blocks
//  i_in.ready until it is taken; no transaction is dropped.
//  Reset (synchronous, active low) returns the sequencer to idle, clears
//  the counters and loads the default timing registers.
//  Timing registers are written through i_cfg_we/i_cfg_idx/i_cfg_data and
//  should only be changed while no sequence is running.
// ----------------------------------------------------------------------------
module single_wire_sensor_reader
    import swsr_pkg::*;
#(
    parameter int BITS_PER_BYTE = BITS_PER_BYTE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    swsr_in_if.sink               i_in,
    swsr_out_if.source            o_out
);

    localparam int BI_W = $clog2(BITS_PER_BYTE + 1);

    t_cfg            r_cfg;
    t_core           r_core, n_core;
    logic [BI_W-1:0] r_bit_idx, n_bit_idx;
    t_result         r_res, n_res;
    logic            r_out_valid;
    logic            in_fire;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_fire    = i_in.valid && i_in.ready;

    // Tick logic
    swsr_step #(
        .BITS_PER_BYTE (BITS_PER_BYTE),
        .BI_W          (BI_W)
    ) u_step (
        .i_cfg     (r_cfg),
        .i_core    (r_core),
        .i_bit_idx (r_bit_idx),
        .i_action  (i_in.action),
        .i_pin     (i_in.pin_level),
        .o_core    (n_core),
        .o_bit_idx (n_bit_idx),
        .o_res     (n_res)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_low    <= START_LOW_RST;
            r_cfg.release_wait <= RELEASE_RST;
            r_cfg.resp_limit   <= RESP_LIMIT_RST;
            r_cfg.bit_sample   <= BIT_SAMPLE_RST;
            r_cfg.one_extra    <= ONE_EXTRA_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START_LOW:  r_cfg.start_low    <= i_cfg_data;
                CFG_RELEASE:    r_cfg.release_wait <= i_cfg_data[7:0];
                CFG_RESP_LIMIT: r_cfg.resp_limit   <= i_cfg_data[7:0];
                CFG_BIT_SAMPLE: r_cfg.bit_sample   <= i_cfg_data[7:0];
                CFG_ONE_EXTRA:  r_cfg.one_extra    <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_core    <= '{phase: PH_IDLE, tick_count: '0, shift_value: '0,
                           low_timed_out: 1'b0};
            r_bit_idx <= '0;
        end else if (in_fire) begin
            r_core    <= n_core;
            r_bit_idx <= n_bit_idx;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire)
            r_res <= n_res;
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.drive_low        = r_res.drive_low;
    assign o_out.busy_res         = r_res.busy_res;
    assign o_out.response_valid   = r_res.response_valid;
    assign o_out.response_timeout = r_res.response_timeout;
    assign o_out.byte_valid       = r_res.byte_valid;
    assign o_out.data_byte        = r_res.data_byte;

    // Checks
    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> o_out.valid)
        else $error("accepted tick produced no result");

    a_drive_in_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.drive_low) |-> o_out.busy_res)
        else $error("line driven outside a sequence");

    a_single_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.response_valid && o_out.byte_valid))
        else $error("response and byte completed on the same tick");

    a_fields_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.byte_valid || (o_out.data_byte == 8'd0)) &&
                         (o_out.response_valid || !o_out.response_timeout)))
        else $error("result field set without its valid flag");

endmodule

[dv/tb_single_wire_sensor_reader.sv]
// ----------------------------------------------------------------------------
// tb_single_wire_sensor_reader
// Self-checking bench for the single-wire sensor reader. Each accepted tick
// transaction is stepped through a local model of the start/response/read
// sequencer, and every result transaction is compared field by field with
// the oldest predicted result. Directed sequences cover the timing register
// extremes and the response and byte corner cases; random sequences with
// a sensor-like line follow, under varying source and sink back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_single_wire_sensor_reader;
    import swsr_pkg::*;

    // Action code the block ignores
    localparam logic [1:0] ACT_RSVD = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    swsr_in_if  in_ch();
    swsr_out_if out_ch();

    single_wire_sensor_reader dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Back-pressure knobs, percent of cycles spent idle
    int src_idle_pct;
    int sink_idle_pct;

    int mismatch_count;
    int ticks_sent;

    // Predicted results still owed by the block
    t_result results_due[$];

    // Local copy of the timing registers and sequencer state
    t_cfg        cfg_shadow;
    t_phase      rd_phase;
    logic [15:0] rd_ticks;
    int          rd_bit;
    logic [7:0]  rd_shift;
    logic        rd_low_to;

    // Sensor line shaping for the current sequence
    int         seq_low_n;
    int         seq_high_n;
    int         seq_gap_n;
    int         gap_cur;
    int         ph_ticks;
    logic [7:0] seq_byte;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 20) begin
            $display("%0t: mismatch: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
        end
    endtask

    // Advance the sequencer model by one tick and return its result
    function automatic t_result step_reader(input logic [1:0] act, input logic pin);
        t_result r;
        logic    bit_done;
        logic    done;
        r = '0;
        bit_done = 1'b0;
        if (rd_phase == PH_IDLE) begin
            if (act == ACT_START) begin
                rd_phase = PH_START_LOW;
                rd_ticks = '0;
            end else if (act == ACT_READ) begin
                rd_phase = PH_WAIT_HIGH;
                rd_ticks = '0;
                rd_bit = 0;
                rd_shift = '0;
            end
        end
        r.busy_res = (rd_phase != PH_IDLE);

        case (rd_phase)
            PH_START_LOW: begin
                r.drive_low = 1'b1;
                rd_ticks = rd_ticks + 16'd1;
                if (rd_ticks >= cfg_shadow.start_low) begin
                    rd_ticks = '0;
                    rd_phase = (cfg_shadow.release_wait == 0) ? PH_RESP_LOW : PH_RELEASE;
                end
            end
            PH_RELEASE: begin
                rd_ticks = rd_ticks + 16'd1;
                if (rd_ticks >= 16'(cfg_shadow.release_wait)) begin
                    rd_ticks = '0;
                    rd_phase = PH_RESP_LOW;
                end
            end
            PH_RESP_LOW: begin
                if (!pin) begin
                    rd_ticks = rd_ticks + 16'd1;
                    if (rd_ticks >= 16'(cfg_shadow.resp_limit)) begin
                        rd_low_to = 1'b1;
                        rd_ticks = '0;
                        rd_phase = PH_RESP_HIGH;
                    end
                end else begin
                    rd_low_to = 1'b0;
                    rd_ticks = '0;
                    rd_phase = PH_RESP_HIGH;
                end
            end
            PH_RESP_HIGH: begin
                done = 1'b1;
                if (pin) begin
                    rd_ticks = rd_ticks + 16'd1;
                    done = (rd_ticks >= 16'(cfg_shadow.resp_limit));
                end
                if (done) begin
                    r.response_valid = 1'b1;
                    r.response_timeout = rd_low_to;
                    rd_ticks = '0;
                    rd_phase = PH_IDLE;
                end
            end
            PH_WAIT_HIGH: begin
                if (pin) begin
                    rd_ticks = '0;
                    rd_phase = PH_BIT_DELAY;
                end
            end
            PH_BIT_DELAY: begin
                rd_ticks = rd_ticks + 16'd1;
                if (rd_ticks >= 16'(cfg_shadow.bit_sample)) begin
                    rd_shift = {rd_shift[6:0], pin};
                    rd_ticks = '0;
                    if (pin && cfg_shadow.one_extra != 0) begin
                        rd_phase = PH_BIT_EXTRA;
                    end else begin
                        bit_done = 1'b1;
                    end
                end
            end
            PH_BIT_EXTRA: begin
                rd_ticks = rd_ticks + 16'd1;
                if (rd_ticks >= 16'(cfg_shadow.one_extra)) begin
                    rd_ticks = '0;
                    bit_done = 1'b1;
                end
            end
            default: begin
                rd_phase = PH_IDLE;
            end
        endcase

        // Bit bookkeeping, byte completes after the last bit
        if (bit_done) begin
            rd_bit++;
            if (rd_bit >= BITS_PER_BYTE_DEF) begin
                r.byte_valid = 1'b1;
                r.data_byte = rd_shift;
                rd_bit = 0;
                rd_phase = PH_IDLE;
            end else begin
                rd_phase = PH_WAIT_HIGH;
            end
        end
        return r;
    endfunction

    function automatic t_cfg timing(input int low_t, input int rel_t, input int lim_t,
                                    input int smp_t, input int ext_t);
        t_cfg c;
        c.start_low = 16'(low_t);
        c.release_wait = 8'(rel_t);
        c.resp_limit = 8'(lim_t);
        c.bit_sample = 8'(smp_t);
        c.one_extra = 8'(ext_t);
        return c;
    endfunction

    function automatic t_cfg random_timing();
        return timing($urandom_range(0, 6), $urandom_range(0, 4), $urandom_range(0, 6),
                      $urandom_range(0, 4), $urandom_range(0, 4));
    endfunction

    function automatic logic [1:0] pick_busy_action();
        logic [1:0] act;
        act = ACT_TICK;
        if ($urandom_range(99) < 6) begin
            case ($urandom_range(2))
                0: act = ACT_START;
                1: act = ACT_READ;
                default: act = ACT_RSVD;
            endcase
        end
        return act;
    endfunction

    // One tick transaction on the input channel, with random source gaps
    task automatic send_tick(input logic [1:0] act, input logic pin);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.action    <= act;
        in_ch.pin_level <= pin;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        results_due.push_back(step_reader(act, pin));
        ticks_sent++;
    endtask

    // Wait for all owed results, then let the block settle
    task automatic drain_results();
        int waited;
        waited = 0;
        in_ch.valid <= 1'b0;
        while (results_due.size() != 0 && waited < 10000) begin
            @(posedge i_clk);
            waited++;
        end
        if (results_due.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      results_due.size()));
            results_due.delete();
        end
        repeat (3) @(posedge i_clk);
    endtask

    // Register write; 8-bit registers get random upper data bits
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        logic [7:0] pad;
        pad = 8'($urandom_range(255));
        if (idx != CFG_START_LOW) begin
            data[15:8] = pad;
        end
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic program_regs(input t_cfg c);
        put_reg(CFG_START_LOW, c.start_low);
        put_reg(CFG_RELEASE, {8'd0, c.release_wait});
        put_reg(CFG_RESP_LIMIT, {8'd0, c.resp_limit});
        put_reg(CFG_BIT_SAMPLE, {8'd0, c.bit_sample});
        put_reg(CFG_ONE_EXTRA, {8'd0, c.one_extra});
        // write to an unmapped index must change nothing
        put_reg(CFG_IDX_W'(CFG_ONE_EXTRA + $urandom_range(1, 3)),
                16'($urandom_range(65535)));
        i_cfg_we <= 1'b0;
        cfg_shadow = c;
    endtask

    // One tick with a line level that behaves like a sensor, or random noise
    task automatic step_line(input logic [1:0] act, input logic noisy);
        t_phase was;
        logic   pin;
        was = rd_phase;
        pin = 1'($urandom_range(1));
        if (!noisy) begin
            case (rd_phase)
                PH_RESP_LOW:  pin = (ph_ticks >= seq_low_n);
                PH_RESP_HIGH: pin = (ph_ticks < seq_high_n);
                PH_WAIT_HIGH: pin = (ph_ticks >= gap_cur);
                PH_BIT_DELAY: pin = seq_byte[BITS_PER_BYTE_DEF - 1 - rd_bit];
                default: ;
            endcase
        end
        send_tick(act, pin);
        if (rd_phase != was) begin
            ph_ticks = 0;
            gap_cur = (seq_gap_n < 0) ? $urandom_range(3) : seq_gap_n;
        end else begin
            ph_ticks++;
        end
    endtask

    task automatic finish_sequence(input logic noisy);
        while (rd_phase != PH_IDLE) begin
            step_line(pick_busy_action(), noisy);
        end
    endtask

    // Start pulse plus response with given low and high phase lengths
    task automatic run_start(input int low_n, input int high_n, input logic noisy);
        seq_low_n = low_n;
        seq_high_n = high_n;
        step_line(ACT_START, noisy);
        finish_sequence(noisy);
    endtask

    // Byte read; a negative gap picks a random wait before each rising edge
    task automatic run_read(input logic [7:0] value, input int gap_n, input logic noisy);
        seq_byte = value;
        seq_gap_n = gap_n;
        step_line(ACT_READ, noisy);
        finish_sequence(noisy);
    endtask

    task automatic run_noise(input int n);
        repeat (n) step_line(2'($urandom_range(3)), 1'b1);
        finish_sequence(1'b1);
    endtask

    // Reset bit timing, no register written yet; last bit one for the extra wait
    task automatic test_reset_timing();
        run_read(8'h01, 0, 1'b0);
    endtask

    // Low phase ending high or at its limit, high phase ending low or at its limit
    task automatic test_response_phases();
        drain_results();
        program_regs(timing(2, 1, 4, 2, 2));
        run_start(0, 2, 1'b0);
        run_start(10, 2, 1'b0);
        run_start(4, 0, 1'b0);
        run_start(3, 10, 1'b0);
        drain_results();
        program_regs(timing(1, 0, 3, 2, 2));
        run_start(2, 1, 1'b0);
        run_start(5, 5, 1'b0);
    endtask

    // Byte patterns, last bit one or zero, with and without extra wait
    task automatic test_byte_decode();
        drain_results();
        program_regs(timing(2, 1, 4, 2, 3));
        run_read(8'h00, 0, 1'b0);
        run_read(8'hFF, 2, 1'b0);
        run_read(8'h01, 0, 1'b0);
        run_read(8'hFE, 1, 1'b0);
        drain_results();
        program_regs(timing(2, 1, 4, 3, 0));
        run_read(8'hFF, 0, 1'b0);
        run_read(8'h5A, -1, 1'b0);
    endtask

    // All timing registers zero act as minimal delays
    task automatic test_zero_timing();
        drain_results();
        program_regs(timing(0, 0, 0, 0, 0));
        run_start(0, 0, 1'b0);
        run_start(3, 3, 1'b0);
        run_read(8'hFF, 0, 1'b0);
        run_read(8'h00, 1, 1'b0);
    endtask

    // Commands while busy and the reserved action are ignored
    task automatic test_busy_commands();
        drain_results();
        program_regs(timing(2, 2, 3, 1, 1));
        step_line(ACT_RSVD, 1'b1);
        step_line(ACT_TICK, 1'b1);
        seq_low_n = 1;
        seq_high_n = 1;
        step_line(ACT_START, 1'b0);
        step_line(ACT_READ, 1'b0);
        step_line(ACT_START, 1'b0);
        step_line(ACT_RSVD, 1'b0);
        finish_sequence(1'b0);
        seq_byte = 8'h96;
        seq_gap_n = 0;
        step_line(ACT_READ, 1'b0);
        step_line(ACT_START, 1'b0);
        step_line(ACT_READ, 1'b0);
        step_line(ACT_RSVD, 1'b0);
        finish_sequence(1'b0);
    endtask

    // 8-bit timing registers at their maximum, short line phases
    task automatic test_max_timing();
        drain_results();
        program_regs(timing(1, 255, 255, 255, 255));
        run_start(0, 0, 1'b0);
    endtask

    // Random sequences and noise, timing reprogrammed every few sequences
    task automatic test_random_traffic(input int n_items);
        int goal;
        int pick;
        int lim;
        int seqs;
        goal = ticks_sent + n_items;
        seqs = 0;
        while (ticks_sent < goal) begin
            if (seqs % 10 == 0) begin
                drain_results();
                program_regs(random_timing());
            end
            seqs++;
            lim = (cfg_shadow.resp_limit == 0) ? 1 : cfg_shadow.resp_limit;
            pick = $urandom_range(9);
            if (pick < 4) begin
                run_start($urandom_range(0, lim + 2), $urandom_range(0, lim + 2),
                          $urandom_range(9) == 0);
            end else if (pick < 8) begin
                run_read(8'($urandom_range(255)), -1, $urandom_range(9) == 0);
            end else if (pick == 8) begin
                run_noise($urandom_range(1, 6));
            end else begin
                repeat ($urandom_range(1, 4)) step_line(ACT_TICK, 1'b1);
            end
        end
    endtask

    // Sink back-pressure
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (results_due.size() == 0) begin
                report_mismatch("result transaction with none expected");
            end else begin
                want = results_due.pop_front();
                check_field("drive_low", 8'(out_ch.drive_low), 8'(want.drive_low));
                check_field("busy_res", 8'(out_ch.busy_res), 8'(want.busy_res));
                check_field("response_valid", 8'(out_ch.response_valid),
                            8'(want.response_valid));
                check_field("response_timeout", 8'(out_ch.response_timeout),
                            8'(want.response_timeout));
                check_field("byte_valid", 8'(out_ch.byte_valid), 8'(want.byte_valid));
                check_field("data_byte", out_ch.data_byte, want.data_byte);
            end
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= '0;
        i_cfg_data      <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.action    <= ACT_TICK;
        in_ch.pin_level <= 1'b1;
        mismatch_count = 0;
        ticks_sent = 0;
        cfg_shadow = timing(int'(START_LOW_RST), int'(RELEASE_RST), int'(RESP_LIMIT_RST),
                            int'(BIT_SAMPLE_RST), int'(ONE_EXTRA_RST));
        rd_phase = PH_IDLE;
        rd_ticks = '0;
        rd_bit = 0;
        rd_shift = '0;
        rd_low_to = 1'b0;
        seq_gap_n = 0;
        gap_cur = 0;
        ph_ticks = 0;
        seq_byte = '0;
        src_idle_pct = 18;
        sink_idle_pct = 62;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_timing();
        test_response_phases();
        test_byte_decode();
        test_zero_timing();
        test_busy_commands();

        src_idle_pct = 62;
        sink_idle_pct = 18;
        test_random_traffic(100);

        src_idle_pct = 0;
        sink_idle_pct = 0;
        test_random_traffic(100);
        test_max_timing();

        drain_results();
        if (mismatch_count == 0) begin
            $display("[single_wire_sensor_reader] OK");
        end else begin
            $display("[single_wire_sensor_reader] ERROR");
        end
        $finish;
    end

    // Run time limit
    initial begin
        #2_000_000;
        $display("[single_wire_sensor_reader] ERROR");
        $finish;
    end

endmodule
